FILE: hdl/hcrd_pkg.sv
// Shared types, constants and helper functions of the hard-clip region detector.
package hcrd_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned MaxSamples    = 1048576;
  localparam int unsigned IdxW          = 20;
  localparam int unsigned CntW          = 21;
  localparam int unsigned ThrW          = 16;
  localparam int unsigned LenCfgW       = 8;
  localparam int unsigned ApbAddrW      = 4;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned MaxResults    = 3;

  localparam logic [IdxW-1:0] IdxLast =
    (MaxSamples > (1 << IdxW)) ? {IdxW{1'b1}} : IdxW'(MaxSamples - 1);
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  localparam logic [ThrW-1:0]    ThresholdRst = 16'd32440;
  localparam logic [LenCfgW-1:0] MinRunRst    = 8'd1;
  localparam logic [LenCfgW-1:0] MergeGapRst  = 8'd0;

  localparam logic [CntW-1:0] SevMildMax     = 21'd4;
  localparam logic [CntW-1:0] SevModerateMax = 21'd16;
  localparam logic [CntW-1:0] SevSevereMax   = 21'd64;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegMinRun    = 2'd1,
    RegMergeGap  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SevMild     = 2'd0,
    SevModerate = 2'd1,
    SevSevere   = 2'd2,
    SevCritical = 2'd3
  } severity_e;

  typedef enum logic {
    KindRegion  = 1'b0,
    KindSummary = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] start_index;
    logic [IdxW-1:0] end_index;
    logic            negative;
    severity_e       severity;
    logic [CntW-1:0] clipped_total;
    logic            final_res;
  } res_t;

  function automatic logic [CntW-1:0] region_len(input logic [IdxW-1:0] first,
                                                 input logic [IdxW-1:0] last);
    region_len = CntW'(last - first) + CntW'(1);
  endfunction

  function automatic severity_e sev_class(input logic [CntW-1:0] len);
    if (len <= SevMildMax) begin
      sev_class = SevMild;
    end else if (len <= SevModerateMax) begin
      sev_class = SevModerate;
    end else if (len <= SevSevereMax) begin
      sev_class = SevSevere;
    end else begin
      sev_class = SevCritical;
    end
  endfunction

  function automatic logic [CntW-1:0] add_sat(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    add_sat = sum[CntW] ? CountMax : sum[CntW-1:0];
  endfunction

  function automatic res_t make_region(input logic [IdxW-1:0] first,
                                       input logic [IdxW-1:0] last,
                                       input logic            neg);
    res_t r;
    r               = '0;
    r.kind          = KindRegion;
    r.start_index   = first;
    r.end_index     = last;
    r.negative      = neg;
    r.severity      = sev_class(region_len(first, last));
    r.clipped_total = '0;
    r.final_res     = 1'b0;
    make_region = r;
  endfunction

  function automatic res_t make_summary(input logic [CntW-1:0] total);
    res_t r;
    r               = '0;
    r.kind          = KindSummary;
    r.severity      = SevMild;
    r.clipped_total = total;
    r.final_res     = 1'b1;
    make_summary = r;
  endfunction

endpackage

FILE: hdl/hard_clip_region_detector.sv
// Hard-clip region detector: sample register, run and region tracking, result queue.
// Each accepted request is held in the input register until the result queue holds at
// most one entry, then its results are written into the queue, whose head drives outputs.
// Throughput: one request per cycle while each yields at most one result and the output
// keeps pace; end of buffer yields up to three results, sent one per cycle as taken;
// a held request drops input ready while the four-entry queue has under three free slots.
// Reset: asynchronous, active low; clears all tracking state and the queue, and returns
// the registers to threshold 32440, minimum run 1, merge gap 0.
module hard_clip_region_detector
  import hcrd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   end_of_buffer_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic [IdxW-1:0]        start_index_o,
  output logic [IdxW-1:0]        end_index_o,
  output logic                   negative_o,
  output logic [1:0]             severity_o,
  output logic [CntW-1:0]        clipped_total_o,
  output logic                   final_res_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0]    pwdata,
  output logic [ApbDataW-1:0]    prdata,
  output logic                   pready
);

  localparam int unsigned CmpW  = (SAMPLE_BITS > ThrW) ? SAMPLE_BITS : ThrW;
  localparam int unsigned QIdxW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);
  localparam int unsigned NewW  = $clog2(MaxResults + 1);

  logic [ThrW-1:0]    thr_q;
  logic [LenCfgW-1:0] min_run_q;
  logic [LenCfgW-1:0] gap_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   eob_q;
  logic                   in_vld_q;
  logic                   fire;

  logic [IdxW-1:0] sidx_q, sidx_d;
  logic            in_run_q, in_run_d;
  logic [IdxW-1:0] run_start_q, run_start_d;
  logic            run_neg_q, run_neg_d;
  logic            pend_vld_q, pend_vld_d;
  logic [IdxW-1:0] pend_start_q, pend_start_d;
  logic [IdxW-1:0] pend_end_q, pend_end_d;
  logic            pend_neg_q, pend_neg_d;
  logic [CntW-1:0] count_q, count_d;

  res_t            new_res [MaxResults+1];
  logic [NewW-1:0] n_new;

  res_t             q_q [QueueDepth];
  res_t             q_d [QueueDepth];
  logic [QCntW-1:0] qcnt_q, qcnt_d;
  logic             pop;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThresholdRst;
      min_run_q <= MinRunRst;
      gap_q     <= MergeGapRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegThreshold: thr_q     <= pwdata[ThrW-1:0];
        RegMinRun:    min_run_q <= pwdata[LenCfgW-1:0];
        RegMergeGap:  gap_q     <= pwdata[LenCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegThreshold: prdata = ApbDataW'(thr_q);
      RegMinRun:    prdata = ApbDataW'(min_run_q);
      RegMergeGap:  prdata = ApbDataW'(gap_q);
      default:      prdata = '0;
    endcase
  end

  // Input register
  assign fire       = in_vld_q && (qcnt_q <= QCntW'(QueueDepth - MaxResults));
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= sample_i;
      eob_q <= end_of_buffer_i;
    end
  end

  // Run and region tracking
  always_comb begin
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   clipped;
    logic [IdxW-1:0]        idx_prev;
    logic                   close_en;
    logic [IdxW-1:0]        rs;
    logic                   rneg;
    logic [IdxW-1:0]        cend;
    logic [CntW-1:0]        run_len;
    logic                   keep;
    logic                   merge;
    logic                   emit_a;
    logic                   emit_b;
    logic                   pv1;
    logic [IdxW-1:0]        ps1;
    logic [IdxW-1:0]        pe1;
    logic                   pn1;
    logic [CntW-1:0]        cnt1;
    logic [CntW-1:0]        cnt2;
    res_t                   res_a;
    res_t                   res_b;
    res_t                   res_s;

    neg      = smp_q[SAMPLE_BITS-1];
    mag      = neg ? SAMPLE_BITS'(~smp_q + 1'b1) : smp_q;
    clipped  = CmpW'(mag) >= CmpW'(thr_q);
    idx_prev = (sidx_q != '0) ? sidx_q - IdxW'(1) : '0;

    close_en = (in_run_q && !clipped) || (eob_q && (in_run_q || clipped));
    rs       = in_run_q ? run_start_q : sidx_q;
    rneg     = in_run_q ? run_neg_q : neg;
    cend     = clipped ? sidx_q : idx_prev;
    if (cend < rs) begin
      cend = rs;
    end
    run_len = region_len(rs, cend);
    keep    = close_en && (run_len >= CntW'(min_run_q));
    merge   = pend_vld_q &&
              (CntW'(rs) <= CntW'(pend_end_q) + CntW'(1) + CntW'(gap_q));

    emit_a = keep && !merge && pend_vld_q;
    res_a  = make_region(pend_start_q, pend_end_q, pend_neg_q);
    cnt1   = emit_a ? add_sat(count_q, region_len(pend_start_q, pend_end_q)) : count_q;

    pv1 = pend_vld_q;
    ps1 = pend_start_q;
    pe1 = pend_end_q;
    pn1 = pend_neg_q;
    if (keep) begin
      if (merge) begin
        if (cend > pend_end_q) begin
          pe1 = cend;
        end
      end else begin
        pv1 = 1'b1;
        ps1 = rs;
        pe1 = cend;
        pn1 = rneg;
      end
    end

    emit_b = eob_q && pv1;
    res_b  = make_region(ps1, pe1, pn1);
    cnt2   = emit_b ? add_sat(cnt1, region_len(ps1, pe1)) : cnt1;
    res_s  = make_summary(cnt2);

    new_res[0]          = emit_a ? res_a : (emit_b ? res_b : res_s);
    new_res[1]          = (emit_a && emit_b) ? res_b : res_s;
    new_res[2]          = res_s;
    new_res[MaxResults] = '0;
    n_new = NewW'(emit_a) + NewW'(emit_b) + NewW'(eob_q);

    if (eob_q) begin
      sidx_d       = '0;
      in_run_d     = 1'b0;
      run_start_d  = '0;
      run_neg_d    = 1'b0;
      pend_vld_d   = 1'b0;
      pend_start_d = '0;
      pend_end_d   = '0;
      pend_neg_d   = 1'b0;
      count_d      = '0;
    end else begin
      sidx_d       = (sidx_q < IdxLast) ? sidx_q + IdxW'(1) : sidx_q;
      in_run_d     = clipped;
      run_start_d  = (clipped && !in_run_q) ? sidx_q : run_start_q;
      run_neg_d    = (clipped && !in_run_q) ? neg : run_neg_q;
      pend_vld_d   = pv1;
      pend_start_d = ps1;
      pend_end_d   = pe1;
      pend_neg_d   = pn1;
      count_d      = cnt1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q       <= '0;
      in_run_q     <= 1'b0;
      run_start_q  <= '0;
      run_neg_q    <= 1'b0;
      pend_vld_q   <= 1'b0;
      pend_start_q <= '0;
      pend_end_q   <= '0;
      pend_neg_q   <= 1'b0;
      count_q      <= '0;
    end else if (fire) begin
      sidx_q       <= sidx_d;
      in_run_q     <= in_run_d;
      run_start_q  <= run_start_d;
      run_neg_q    <= run_neg_d;
      pend_vld_q   <= pend_vld_d;
      pend_start_q <= pend_start_d;
      pend_end_q   <= pend_end_d;
      pend_neg_q   <= pend_neg_d;
      count_q      <= count_d;
    end
  end

  // Result queue, head at entry zero
  assign out_valid_o = (qcnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    logic [QCntW-1:0] base;
    logic [QCntW-1:0] push_n;
    logic [QCntW-1:0] off;

    base   = qcnt_q - QCntW'(pop);
    push_n = fire ? QCntW'(n_new) : '0;
    for (int i = 0; i < QueueDepth; i++) begin
      off = QCntW'(i) - base;
      if (QCntW'(i) < base) begin
        q_d[i] = pop ? q_q[QIdxW'(i + 1)] : q_q[i];
      end else if (off < push_n) begin
        q_d[i] = new_res[off[NewW-1:0]];
      end else begin
        q_d[i] = q_q[i];
      end
    end
    qcnt_d = base + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else begin
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign kind_o          = q_q[0].kind;
  assign start_index_o   = q_q[0].start_index;
  assign end_index_o     = q_q[0].end_index;
  assign negative_o      = q_q[0].negative;
  assign severity_o      = q_q[0].severity;
  assign clipped_total_o = q_q[0].clipped_total;
  assign final_res_o     = q_q[0].final_res;

endmodule
